// ===== hw/rtl/keyword_substitution_cipher_defines.svh =====
// Assertion macros for the keyword substitution cipher.
// Used by the controller; expects clk_i and rst_ni in scope.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_DEFINES_SVH

// same-cycle implication
`define KWSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kwsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the keyword substitution cipher.
// No dependencies; imported by the controller, datapath and top level.
package kwsc_pkg;

  localparam int unsigned IDX_W = 5;

  localparam logic [IDX_W-1:0] FIRST_IDX = 5'd0;
  localparam logic [IDX_W-1:0] LAST_IDX  = 5'd25;
  localparam logic [IDX_W-1:0] FILL_FULL = 5'd26;

  localparam logic [7:0] ASCII_UA = 8'h41;
  localparam logic [7:0] ASCII_UZ = 8'h5A;
  localparam logic [7:0] ASCII_LA = 8'h61;
  localparam logic [7:0] ASCII_LZ = 8'h7A;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_KEY    = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_TEXT   = 2'd3
  } func_e;

  typedef struct packed {
    logic             clear_key;
    logic             add_key;
    logic             walk_add;
    logic             walk_rd;
    logic             text;
    logic             key_ready;
    logic [IDX_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic fill_full;
  } stat_t;

endpackage

// ===== hw/rtl/kwsc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the keyword substitution cipher: sequences key start,
// finish walk and inverse build. Depends on kwsc_pkg and the defines header.
`include "keyword_substitution_cipher_defines.svh"
module kwsc_ctrl import kwsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] func_i,
  input  stat_t      stat_i,
  output logic       busy,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FILL  = 4'b0010,
    ST_INV   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             ready_q, ready_d;
  logic             acc;
  func_e            func;

  assign busy = (state_q != ST_IDLE);
  assign acc  = start && !busy;
  assign func = func_e'(func_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ready_d = ready_q;
    cmd_o   = '0;
    cmd_o.cnt       = cnt_q;
    cmd_o.key_ready = ready_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (func)
            FUNC_START: begin
              cmd_o.clear_key = 1'b1;
              ready_d         = 1'b0;
            end
            FUNC_KEY: begin
              cmd_o.add_key = !ready_q;
            end
            FUNC_FINISH: begin
              if (!ready_q) begin
                state_d = ST_FILL;
                cnt_d   = LAST_IDX;
              end
            end
            FUNC_TEXT: begin
              cmd_o.text = 1'b1;
            end
            default: begin
              cmd_o.text = 1'b0;
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.walk_add = 1'b1;
        if (stat_i.fill_full || cnt_q == FIRST_IDX) begin
          state_d = ST_INV;
          cnt_d   = FIRST_IDX;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_INV: begin
        cmd_o.walk_rd = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        ready_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= FIRST_IDX;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ready_q <= ready_d;
    end
  end

  `KWSC_ASSERT_NEXT(a_start_clears_ready, acc && func == FUNC_START, !ready_q,
                    "start transaction did not clear key ready")
  `KWSC_ASSERT_NEXT(a_inv_to_drain, state_q == ST_INV && cnt_q == LAST_IDX,
                    state_q == ST_DRAIN, "inverse walk did not end in drain")
  `KWSC_ASSERT_NEXT(a_drain_sets_ready, state_q == ST_DRAIN,
                    ready_q && state_q == ST_IDLE, "drain did not finish the key")
  `KWSC_ASSERT_NOW(a_inv_after_full, state_q == ST_INV, stat_i.fill_full,
                   "inverse build began on a partial cipher alphabet")

endmodule

// ===== hw/rtl/kwsc_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the keyword substitution cipher: used-letter marks, fill
// index, forward and inverse tables, result register. Depends on kwsc_pkg.
module kwsc_dp import kwsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_decrypt_mode_i,
  output stat_t      stat_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       key_ready_o
);

  logic [25:0]      used_q, used_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic             mode_q;

  logic [IDX_W-1:0] fwd_mem [26];
  logic [IDX_W-1:0] inv_mem [26];
  logic [IDX_W-1:0] fwd_rd_q, inv_rd_q;
  logic             inv_wr_q;
  logic [IDX_W-1:0] inv_j_q;

  logic             valid_q, letter_q, kr_q, sel_q;
  logic [7:0]       byte_q;

  logic             is_letter;
  logic [IDX_W-1:0] li;
  logic [7:0]       diff;
  logic             fill_full;
  logic             fwd_we;
  logic [IDX_W-1:0] fwd_wdata;
  logic [IDX_W-1:0] fwd_raddr;
  logic [IDX_W-1:0] m;

  always_comb begin
    diff      = 8'h00;
    is_letter = 1'b0;
    if (data_byte_i inside {[ASCII_UA:ASCII_UZ]}) begin
      diff      = data_byte_i - ASCII_UA;
      is_letter = 1'b1;
    end else if (data_byte_i inside {[ASCII_LA:ASCII_LZ]}) begin
      diff      = data_byte_i - ASCII_LA;
      is_letter = 1'b1;
    end
    li = diff[IDX_W-1:0];
  end

  assign fill_full        = (fill_q == FILL_FULL);
  assign stat_o.fill_full = fill_full;

  always_comb begin
    fwd_we    = 1'b0;
    fwd_wdata = li;
    if (cmd_i.add_key) begin
      fwd_we = is_letter && !used_q[li] && !fill_full;
    end else if (cmd_i.walk_add) begin
      fwd_we    = !used_q[cmd_i.cnt] && !fill_full;
      fwd_wdata = cmd_i.cnt;
    end
    used_d = used_q;
    fill_d = fill_q;
    if (cmd_i.clear_key) begin
      used_d = '0;
      fill_d = FIRST_IDX;
    end else if (fwd_we) begin
      used_d[fwd_wdata] = 1'b1;
      fill_d            = fill_q + 1'b1;
    end
    fwd_raddr = cmd_i.walk_rd ? cmd_i.cnt : li;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      fill_q   <= FIRST_IDX;
      mode_q   <= 1'b0;
      inv_wr_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      used_q   <= used_d;
      fill_q   <= fill_d;
      inv_wr_q <= cmd_i.walk_rd;
      valid_q  <= cmd_i.text;
      if (cfg_valid_i) begin
        mode_q <= cfg_decrypt_mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[fill_q] <= fwd_wdata;
    end
    if (cmd_i.walk_rd || cmd_i.text) begin
      fwd_rd_q <= fwd_mem[fwd_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (inv_wr_q) begin
      inv_mem[fwd_rd_q] <= inv_j_q;
    end
    if (cmd_i.text) begin
      inv_rd_q <= inv_mem[li];
    end
  end

  always_ff @(posedge clk_i) begin
    inv_j_q <= cmd_i.cnt;
    if (cmd_i.text) begin
      byte_q   <= data_byte_i;
      letter_q <= is_letter;
      kr_q     <= cmd_i.key_ready;
      sel_q    <= mode_q;
    end
  end

  assign m           = sel_q ? inv_rd_q : fwd_rd_q;
  assign out_valid_o = valid_q;
  assign out_byte_o  = (kr_q && letter_q) ? (ASCII_UA + 8'(m)) : byte_q;
  assign key_ready_o = kr_q;

endmodule

// ===== hw/rtl/keyword_substitution_cipher.sv =====
`timescale 1ns / 1ps
// Top level of the keyword substitution cipher.
// Depends on kwsc_pkg, kwsc_ctrl and kwsc_dp.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  command  | start, busy               | func_i, data_byte_i
//  result   | out_valid_o (one cycle)   | out_byte_o, key_ready_o
//  config   | cfg_valid_i, cfg_ready_o  | cfg_decrypt_mode_i
//
// Start, keyword and text transactions do not raise busy; a text result
// appears the cycle after its transaction, set by the registered table read.
// A finish transaction on a key that is not yet ready holds busy high through
// the fill walk, the inverse build (one forward-table read port) and the drain state.
// Reset clears the used-letter marks, fill index, key ready and mode.
// The receiver cannot stall; config writes are always taken.
module keyword_substitution_cipher import kwsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       key_ready_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_decrypt_mode_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  kwsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  kwsc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .data_byte_i        (data_byte_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_decrypt_mode_i (cfg_decrypt_mode_i),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_byte_o         (out_byte_o),
    .key_ready_o        (key_ready_o)
  );

endmodule

// ===== test/tb_keyword_substitution_cipher.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keyword_substitution_cipher: keyword, finish and text
// transactions feed a cipher-table predictor in a scoreboard that checks text results.
// Depends on kwsc_pkg and the keyword_substitution_cipher RTL only.
module tb_keyword_substitution_cipher import kwsc_pkg::*;;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned SETTLE       = 64;
  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned NUM_LETTERS  = 26;

  typedef struct {
    logic [7:0] out_byte;
    logic       key_ready;
  } cipher_out_t;

  class cipher_scoreboard;
    bit          used [NUM_LETTERS];
    logic [4:0]  fwd  [NUM_LETTERS];
    logic [4:0]  inv  [NUM_LETTERS];
    logic [4:0]  fill;
    bit          ready;
    bit          decrypt;
    cipher_out_t out_due_q [$];
    int          errors;
    int          results_checked;
    int          keys_built;

    function new();
      used            = '{default: 1'b0};
      fwd             = '{default: 5'd0};
      inv             = '{default: 5'd0};
      fill            = '0;
      ready           = 1'b0;
      decrypt         = 1'b0;
      errors          = 0;
      results_checked = 0;
      keys_built      = 0;
    endfunction

    function int letter_index(logic [7:0] b);
      if (b >= ASCII_UA && b <= ASCII_UZ) return int'(b - ASCII_UA);
      if (b >= ASCII_LA && b <= ASCII_LZ) return int'(b - ASCII_LA);
      return -1;
    endfunction

    function void add_letter(int idx);
      if (!used[idx] && fill < NUM_LETTERS) begin
        fwd[fill] = 5'(idx);
        fill      = fill + 5'd1;
        used[idx] = 1'b1;
      end
    endfunction

    function void build_key();
      for (int i = NUM_LETTERS - 1; i >= 0; i--) add_letter(i);
      for (int j = 0; j < NUM_LETTERS; j++) inv[fwd[j]] = 5'(j);
      ready = 1'b1;
      keys_built++;
    endfunction

    function void set_mode(logic m);
      decrypt = m;
    endfunction

    function int pending();
      return out_due_q.size();
    endfunction

    function void note_item(func_e f, logic [7:0] d);
      int          idx;
      cipher_out_t rec;
      idx = letter_index(d);
      case (f)
        FUNC_START: begin
          used  = '{default: 1'b0};
          fill  = '0;
          ready = 1'b0;
        end
        FUNC_KEY: begin
          if (!ready && idx >= 0) add_letter(idx);
        end
        FUNC_FINISH: begin
          if (!ready) build_key();
        end
        default: begin
          rec.key_ready = ready;
          if (ready && idx >= 0)
            rec.out_byte = ASCII_UA + {3'b000, (decrypt ? inv[idx] : fwd[idx])};
          else
            rec.out_byte = d;
          out_due_q.push_back(rec);
        end
      endcase
    endfunction

    function void check_result(logic [7:0] ob, logic kr);
      cipher_out_t exp_rec;
      if (out_due_q.size() == 0) begin
        $error("unexpected result: out_byte %h key_ready %b", ob, kr);
        errors++;
        return;
      end
      exp_rec = out_due_q.pop_front();
      results_checked++;
      if (ob !== exp_rec.out_byte) begin
        $error("out_byte mismatch: expected %h, actual %h", exp_rec.out_byte, ob);
        errors++;
      end
      if (kr !== exp_rec.key_ready) begin
        $error("key_ready mismatch: expected %b, actual %b", exp_rec.key_ready, kr);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i              = 1'b0;
  logic       rst_ni             = 1'b0;
  logic       start              = 1'b0;
  logic [1:0] func_i             = FUNC_START;
  logic [7:0] data_byte_i        = 8'h00;
  logic       cfg_valid_i        = 1'b0;
  logic       cfg_decrypt_mode_i = 1'b0;
  logic       busy;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       key_ready_o;
  logic       cfg_ready_o;

  cipher_scoreboard sb = new();
  int unsigned      cycle_count = 0;
  int               items_sent  = 0;
  int               mode_writes = 0;
  int               burst_left  = 0;
  bit               gaps_on     = 1'b1;

  keyword_substitution_cipher i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_byte_o        (out_byte_o),
    .key_ready_o       (key_ready_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_decrypt_mode_i(cfg_decrypt_mode_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o) sb.check_result(out_byte_o, key_ready_o);
      if (cfg_valid_i && cfg_ready_o) sb.set_mode(cfg_decrypt_mode_i);
      if (start && !busy) sb.note_item(func_e'(func_i), data_byte_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] idx;
    idx = 8'($urandom_range(0, NUM_LETTERS - 1));
    return $urandom_range(0, 1) ? ASCII_UA + idx : ASCII_LA + idx;
  endfunction

  function automatic logic [7:0] rand_text();
    return $urandom_range(0, 1) ? rand_letter() : 8'($urandom_range(0, 255));
  endfunction

  task automatic hold_off(input int n);
    start       <= 1'b0;
    func_i      <= 2'($urandom_range(0, 3));
    data_byte_i <= 8'($urandom_range(0, 255));
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_item(input func_e f, input logic [7:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) hold_off($urandom_range(1, 6));
    end
    burst_left--;
    start       <= 1'b1;
    func_i      <= f;
    data_byte_i <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    hold_off(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid_i        <= 1'b1;
    cfg_decrypt_mode_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mode_writes++;
  endtask

  task automatic send_noise();
    send_item(func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_key_sequence();
    logic [7:0] perm [NUM_LETTERS];
    logic [7:0] tmp;
    int         k;
    int         n_key;
    int         n_text;
    if ($urandom_range(0, 9) == 0) send_noise();
    if ($urandom_range(0, 9) != 0) send_item(FUNC_START, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      for (int i = 0; i < NUM_LETTERS; i++) perm[i] = ASCII_UA + 8'(i);
      for (int i = NUM_LETTERS - 1; i > 0; i--) begin
        k       = $urandom_range(0, i);
        tmp     = perm[i];
        perm[i] = perm[k];
        perm[k] = tmp;
      end
      for (int i = 0; i < NUM_LETTERS; i++)
        send_item(FUNC_KEY, $urandom_range(0, 1) ? perm[i] : perm[i] + 8'h20);
      send_item(FUNC_KEY, rand_letter());
    end else begin
      n_key = $urandom_range(0, 12);
      for (int i = 0; i < n_key; i++) begin
        if ($urandom_range(0, 9) == 0) send_item(FUNC_TEXT, rand_text());
        if ($urandom_range(0, 4) == 0) send_item(FUNC_KEY, 8'($urandom_range(0, 255)));
        else                           send_item(FUNC_KEY, rand_letter());
      end
    end
    if ($urandom_range(0, 11) != 0) send_item(FUNC_FINISH, 8'($urandom_range(0, 255)));
    n_text = $urandom_range(1, 30);
    for (int i = 0; i < n_text; i++) begin
      if ($urandom_range(0, 19) == 0) send_noise();
      send_item(FUNC_TEXT, rand_text());
    end
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(FUNC_TEXT, 8'h61);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_TEXT, ASCII_UA);
    send_item(FUNC_TEXT, ASCII_LZ);
    send_item(FUNC_TEXT, 8'h40);
    send_item(FUNC_TEXT, 8'h5B);
    send_item(FUNC_TEXT, 8'h60);
    send_item(FUNC_TEXT, 8'h7B);
    send_item(FUNC_TEXT, 8'h80);
    send_item(FUNC_KEY, 8'h51);
    send_item(FUNC_FINISH, 8'hFF);
    send_item(FUNC_TEXT, 8'h71);
    send_item(FUNC_START, 8'hFF);
    send_item(FUNC_TEXT, 8'h6D);
    send_item(FUNC_KEY, ASCII_UZ);
    send_item(FUNC_KEY, 8'h65);
    send_item(FUNC_KEY, ASCII_LZ);
    send_item(FUNC_KEY, 8'h21);
    send_item(FUNC_KEY, 8'hC1);
    send_item(FUNC_KEY, 8'h42);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_TEXT, ASCII_UZ);
    write_mode(1'b1);
    send_item(FUNC_TEXT, ASCII_UA);
    send_item(FUNC_TEXT, 8'h65);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      run_key_sequence();
      phase++;
      if (phase % 3 == 0)
        write_mode((phase % 6 == 0) ? ~sb.decrypt : 1'($urandom_range(0, 1)));
    end

    drain();
    $display("Sent %0d transactions over %0d keys and %0d mode writes",
             items_sent, sb.keys_built, mode_writes);
    $display("Checked %0d text results, %0d errors", sb.results_checked, sb.errors);
    if (sb.errors == 0) $display("Simulation PASSED");
    else                $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/kwsc_pkg.sv
hw/rtl/kwsc_ctrl.sv
hw/rtl/kwsc_dp.sv
hw/rtl/keyword_substitution_cipher.sv
test/tb_keyword_substitution_cipher.sv
